FILE: src/plst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and fixed port widths of the positional list store.
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int unsigned PosWidth    = 6;
  localparam int unsigned InDataWidth = 32;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_ERASE  = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EVAL  = 2'd1,
    S_SHIFT = 2'd2,
    S_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic    done;
    logic    read_ok;
    status_e status;
  } result_t;

endpackage
`default_nettype wire

FILE: src/plst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plst_ctrl
// Request sequencer: checks each item, drives the entry memory one read and
// one write per cycle to shift entries, and tracks the element count.
// ----------------------------------------------------------------------------
module plst_ctrl #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = $clog2(CAPACITY),
  parameter int unsigned CW         = $clog2(CAPACITY + 1)
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [1:0]                            req_type_i,
  input  wire  [plst_pkg::PosWidth-1:0]         position_i,
  input  wire  [plst_pkg::InDataWidth-1:0]      data_in_i,
  output plst_pkg::result_t                     result_o,
  output logic [CW-1:0]                         count_o,
  output logic                                  mem_rd_en_o,
  output logic [AW-1:0]                         mem_rd_addr_o,
  output logic                                  mem_wr_en_o,
  output logic [AW-1:0]                         mem_wr_addr_o,
  output logic [DATA_WIDTH-1:0]                 mem_wr_data_o,
  input  wire  [DATA_WIDTH-1:0]                 mem_rd_data_i
);

  localparam logic [AW-1:0] OneA = AW'(1);
  localparam logic [CW-1:0] OneC = CW'(1);

  plst_pkg::state_e  state_q, state_d;
  plst_pkg::req_e    req_q, req_d;
  plst_pkg::status_e status_q, status_d;
  logic [plst_pkg::PosWidth-1:0] pos_q, pos_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [AW-1:0] src_q, src_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          pend_q, pend_d;
  logic          read_ok_q, read_ok_d;

  logic [15:0] pos_ext;
  logic [15:0] cnt_ext;
  logic [63:0] din_ext;
  logic [AW-1:0] pos_a;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] cnt_m1;
  logic range_err;
  logic full;

  assign pos_ext   = 16'(pos_q);
  assign cnt_ext   = 16'(count_q);
  assign din_ext   = 64'(data_in_i);
  assign pos_a     = pos_ext[AW-1:0];
  assign pos_c     = pos_ext[CW-1:0];
  assign cnt_m1    = count_q - OneC;
  assign range_err = (pos_ext >= cnt_ext);
  assign full      = (cnt_ext >= 16'(CAPACITY));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      plst_pkg::S_IDLE: begin
        if (start) begin
          state_d = plst_pkg::S_EVAL;
        end
      end
      plst_pkg::S_EVAL: begin
        if (req_q == plst_pkg::REQ_APPEND || req_q == plst_pkg::REQ_READ || range_err ||
            (req_q == plst_pkg::REQ_INSERT && full)) begin
          state_d = plst_pkg::S_DONE;
        end else begin
          state_d = plst_pkg::S_SHIFT;
        end
      end
      plst_pkg::S_SHIFT: begin
        if (rem_q == '0) begin
          state_d = plst_pkg::S_DONE;
        end
      end
      plst_pkg::S_DONE: begin
        state_d = plst_pkg::S_IDLE;
      end
      default: state_d = plst_pkg::S_IDLE;
    endcase
  end

  // Outputs and memory port
  always_comb begin
    busy             = (state_q != plst_pkg::S_IDLE);
    result_o.done    = (state_q == plst_pkg::S_DONE);
    result_o.read_ok = read_ok_q;
    result_o.status  = status_q;
    count_o          = count_q;
    mem_rd_en_o      = 1'b0;
    mem_rd_addr_o    = src_q;
    mem_wr_en_o      = 1'b0;
    mem_wr_addr_o    = pend_addr_q;
    mem_wr_data_o    = mem_rd_data_i;
    case (state_q)
      plst_pkg::S_EVAL: begin
        if (req_q == plst_pkg::REQ_APPEND) begin
          mem_wr_en_o   = !full;
          mem_wr_addr_o = count_q[AW-1:0];
          mem_wr_data_o = data_q;
        end else if (req_q == plst_pkg::REQ_READ) begin
          mem_rd_en_o   = !range_err;
          mem_rd_addr_o = pos_a;
        end
      end
      plst_pkg::S_SHIFT: begin
        mem_rd_en_o = (rem_q != '0);
        mem_wr_en_o = pend_q;
      end
      plst_pkg::S_DONE: begin
        if (req_q == plst_pkg::REQ_INSERT && status_q == plst_pkg::ST_OK) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = pos_a;
          mem_wr_data_o = data_q;
        end
      end
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    req_d       = req_q;
    pos_d       = pos_q;
    data_d      = data_q;
    status_d    = status_q;
    count_d     = count_q;
    rem_d       = rem_q;
    src_d       = src_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    read_ok_d   = read_ok_q;
    case (state_q)
      plst_pkg::S_IDLE: begin
        if (start) begin
          req_d  = plst_pkg::req_e'(req_type_i);
          pos_d  = position_i;
          data_d = din_ext[DATA_WIDTH-1:0];
        end
      end
      plst_pkg::S_EVAL: begin
        status_d  = plst_pkg::ST_OK;
        read_ok_d = 1'b0;
        pend_d    = 1'b0;
        case (req_q)
          plst_pkg::REQ_APPEND: begin
            if (full) begin
              status_d = plst_pkg::ST_FULL;
            end else begin
              count_d = count_q + OneC;
            end
          end
          plst_pkg::REQ_INSERT: begin
            if (range_err) begin
              status_d = plst_pkg::ST_RANGE;
            end else if (full) begin
              status_d = plst_pkg::ST_FULL;
            end else begin
              src_d = cnt_m1[AW-1:0];
              rem_d = count_q - pos_c;
            end
          end
          plst_pkg::REQ_ERASE: begin
            if (range_err) begin
              status_d = plst_pkg::ST_RANGE;
            end else begin
              src_d = pos_a + OneA;
              rem_d = cnt_m1 - pos_c;
            end
          end
          plst_pkg::REQ_READ: begin
            if (range_err) begin
              status_d = plst_pkg::ST_RANGE;
            end else begin
              read_ok_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      plst_pkg::S_SHIFT: begin
        if (rem_q != '0) begin
          rem_d  = rem_q - OneC;
          pend_d = 1'b1;
          if (req_q == plst_pkg::REQ_INSERT) begin
            src_d       = src_q - OneA;
            pend_addr_d = src_q + OneA;
          end else begin
            src_d       = src_q + OneA;
            pend_addr_d = src_q - OneA;
          end
        end else begin
          pend_d = 1'b0;
          if (req_q == plst_pkg::REQ_INSERT) begin
            count_d = count_q + OneC;
          end else begin
            count_d = cnt_m1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= plst_pkg::S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      read_ok_q <= 1'b0;
      status_q  <= plst_pkg::ST_OK;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      read_ok_q <= read_ok_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    pos_q       <= pos_d;
    data_q      <= data_d;
    rem_q       <= rem_d;
    src_q       <= src_d;
    pend_addr_q <= pend_addr_d;
  end

endmodule
`default_nettype wire

FILE: src/positional_list_store_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store_core
// Bounded ordered list of data words with append, insert, erase and read.
//
// Raise start with req_type_i, position_i and data_in_i; the item is taken
// at an edge where start is high and busy is low. Exactly one result per
// item appears on read_data_o, count_after_o and status_o for one cycle,
// marked by done_o; it cannot be held off.
// Entries live in one synchronous RAM (one read and one write port,
// registered read data). Insert and erase move entries one per cycle
// through that RAM, reading one entry ahead of the write. Busy drops in
// the cycle after the result strobe.
// Reset clears the count and the sequencer; the RAM is not cleared, since
// only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_store_core #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     start,
  output logic                                    busy,
  input  wire  [1:0]                              req_type_i,
  input  wire  [plst_pkg::PosWidth-1:0]           position_i,
  input  wire  [plst_pkg::InDataWidth-1:0]        data_in_i,
  output logic                                    done_o,
  output logic [plst_pkg::InDataWidth-1:0]        read_data_o,
  output logic [plst_pkg::CountWidth-1:0]         count_after_o,
  output logic [plst_pkg::StatusWidth-1:0]        status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_q;

  plst_pkg::result_t     result;
  logic [CW-1:0]         count;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [63:0]           rd_ext;
  logic [15:0]           cnt_ext;

  plst_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .data_in_i     (data_in_i),
    .result_o      (result),
    .count_o       (count),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data),
    .mem_rd_data_i (rd_data_q)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign rd_ext        = 64'(rd_data_q);
  assign cnt_ext       = 16'(count);
  assign done_o        = result.done;
  assign read_data_o   = result.read_ok ? rd_ext[plst_pkg::InDataWidth-1:0] : '0;
  assign count_after_o = cnt_ext[plst_pkg::CountWidth-1:0];
  assign status_o      = result.status;

endmodule
`default_nettype wire
